FILE: rtl/core/glpc_pkg.sv
// Shared constants and types for the lattice path counter.
// Used by the serial multiplier, the serial divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package glpc_pkg;

   // Width of one grid dimension on the request side.
   localparam int DIM_W = 6;
   // Width of the running product; every intermediate value fits in it.
   localparam int PROD_W = 64;
   // Width of the path count on the response side.
   localparam int PATH_W = 59;
   // Width of the divisor; the step index never exceeds 31.
   localparam int DIVS_W = 5;
   // Default largest grid dimension.
   localparam int MAX_DIM_DEF = 32;

   // Status of one serial arithmetic unit.
   typedef struct packed {
      logic busy;
      logic done;
   } glpc_unit_sts_type;

endpackage : glpc_pkg

`default_nettype wire

FILE: rtl/core/glpc_mul.sv
// Shift-add multiplier that retires one multiplier bit per cycle.
// Depends on glpc_pkg for widths and the unit status struct.
`timescale 1ns / 1ps
`default_nettype none

module glpc_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [glpc_pkg::PROD_W-1:0]   mcand,
   input  wire logic [glpc_pkg::DIM_W-1:0]    mplier,
   output logic [glpc_pkg::PROD_W-1:0]        product,
   output glpc_pkg::glpc_unit_sts_type        sts
);
   import glpc_pkg::*;

   localparam int CNT_W = $clog2(DIM_W + 1);

   logic [PROD_W-1:0] mcand_ff,  mcand_in;
   logic [DIM_W-1:0]  mplier_ff, mplier_in;
   logic [PROD_W-1:0] prod_ff,   prod_in;
   logic [CNT_W-1:0]  cnt_ff,    cnt_in;
   logic              busy_ff,   busy_in;
   logic              done_ff,   done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         prod_in   = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[DIM_W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product  = prod_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule : glpc_mul

`default_nettype wire

FILE: rtl/core/glpc_div.sv
// Restoring radix-2 divider: one quotient bit per cycle, narrow remainder.
// Depends on glpc_pkg for widths and the unit status struct.
`timescale 1ns / 1ps
`default_nettype none

module glpc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [glpc_pkg::PROD_W-1:0]   dividend,
   input  wire logic [glpc_pkg::DIVS_W-1:0]   divisor,
   output logic [glpc_pkg::PROD_W-1:0]        quotient,
   output glpc_pkg::glpc_unit_sts_type        sts
);
   import glpc_pkg::*;

   localparam int CNT_W = $clog2(PROD_W + 1);
   localparam int REM_W = DIVS_W + 1;

   logic [PROD_W-1:0] quo_ff,  quo_in;
   logic [DIVS_W-1:0] dvs_ff,  dvs_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  trial;
   logic              fits;

   // The remainder stays below the divisor, so the shifted trial value
   // never needs more than one extra bit.
   always_comb begin
      trial   = {rem_ff[REM_W-2:0], quo_ff[PROD_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, dvs_ff}) : trial;
         quo_in = {quo_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule : glpc_div

`default_nettype wire

FILE: rtl/core/grid_lattice_path_count.sv
// Counts the monotone corner-to-corner paths of a rows by columns grid, which is
// C(rows+cols-2, cols-1), exactly in 64-bit unsigned arithmetic. Dimensions of
// zero read as one and dimensions above MAX_DIM read as MAX_DIM. One request is
// worked on at a time in (cols-1) steps, each a bit-serial multiply and then a
// bit-serial exact divide; a single-column grid goes straight to the response. A
// finished result waits in the response register while the next request is accepted.
// Depends on glpc_pkg, glpc_mul and glpc_div.
`timescale 1ns / 1ps
`default_nettype none

module grid_lattice_path_count #(
   parameter int MAX_DIM = glpc_pkg::MAX_DIM_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [5:0] grid_rows, [11:6] grid_cols, rest zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata    // [58:0] path_count, rest zero
);
   import glpc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MSTART = 5'b00010,
      ST_MWAIT  = 5'b00100,
      ST_DWAIT  = 5'b01000,
      ST_PUSH   = 5'b10000
   } state_type;

   state_type         state_ff,  state_in;
   logic [DIM_W-1:0]  rows_ff,   rows_in;
   logic [DIM_W-1:0]  cols_ff,   cols_in;
   logic [DIM_W-1:0]  idx_ff,    idx_in;
   logic [PROD_W-1:0] acc_ff,    acc_in;
   logic              rvalid_ff, rvalid_in;
   logic [PATH_W-1:0] rdata_ff,  rdata_in;

   logic [DIM_W-1:0]  raw_rows, raw_cols, clamp_rows, clamp_cols;
   logic [DIM_W-1:0]  next_idx;
   logic [DIM_W-1:0]  factor;
   logic              req_fire, rsp_free;
   logic              mul_start, div_start;
   logic [PROD_W-1:0] mul_prod, div_quo;
   glpc_unit_sts_type mul_sts, div_sts;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   assign raw_rows   = req_tdata[DIM_W-1:0];
   assign raw_cols   = req_tdata[2*DIM_W-1:DIM_W];
   assign clamp_rows = clamp_dim(raw_rows);
   assign clamp_cols = clamp_dim(raw_cols);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rvalid_ff || rsp_tready;

   // Step i multiplies by rows-1+i, then divides exactly by i.
   assign factor    = rows_ff + idx_ff - DIM_W'(1);
   assign next_idx  = idx_ff + DIM_W'(1);
   assign mul_start = (state_ff == ST_MSTART);
   assign div_start = (state_ff == ST_MWAIT) && mul_sts.done;

   glpc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (acc_ff),
      .mplier  (factor),
      .product (mul_prod),
      .sts     (mul_sts)
   );

   glpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_prod),
      .divisor  (idx_ff[DIVS_W-1:0]),
      .quotient (div_quo),
      .sts      (div_sts)
   );

   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      rvalid_in = rvalid_ff;
      rdata_in  = rdata_ff;
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rows_in  = clamp_rows;
               cols_in  = clamp_cols;
               idx_in   = DIM_W'(1);
               acc_in   = PROD_W'(1);
               state_in = (clamp_cols == DIM_W'(1)) ? ST_PUSH : ST_MSTART;
            end
         end
         ST_MSTART: begin
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mul_sts.done) begin
               state_in = ST_DWAIT;
            end
         end
         ST_DWAIT: begin
            if (div_sts.done) begin
               acc_in   = div_quo;
               idx_in   = next_idx;
               state_in = (next_idx == cols_ff) ? ST_PUSH : ST_MSTART;
            end
         end
         ST_PUSH: begin
            if (rsp_free) begin
               rvalid_in = 1'b1;
               rdata_in  = acc_ff[PATH_W-1:0];
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rows_ff  <= rows_in;
      cols_ff  <= cols_in;
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      rdata_ff <= rdata_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {{(64 - PATH_W){1'b0}}, rdata_ff};

`ifndef SYNTHESIS
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_sts.busy && div_sts.busy))
      else $error("multiplier and divider busy at the same time");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == ST_MWAIT))
      else $error("multiplier finished outside its wait state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_DWAIT))
      else $error("divider finished outside its wait state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");
`endif

endmodule : grid_lattice_path_count

`default_nettype wire

FILE: bench/tb_grid_lattice_path_count.sv
// Self-checking bench for grid_lattice_path_count: drives grid sizes on the request
// stream, predicts each exact path count and checks it against the response stream.
// Depends on glpc_pkg and the grid_lattice_path_count RTL.
`timescale 1ns / 1ps

module tb_grid_lattice_path_count;
   import glpc_pkg::*;

   class path_count_board;
      typedef struct {
         bit [DIM_W-1:0]  rows;
         bit [DIM_W-1:0]  cols;
         bit [PATH_W-1:0] count;
      } path_expect_type;

      path_expect_type pending_paths[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      function int clamp_dim(bit [DIM_W-1:0] dim);
         if (dim < 1) return 1;
         if (dim > MAX_DIM_DEF) return MAX_DIM_DEF;
         return int'(dim);
      endfunction

      // Running product acc = acc * (rows-1+i) / i; each division is exact.
      function bit [63:0] lattice_paths(bit [DIM_W-1:0] rows_in, bit [DIM_W-1:0] cols_in);
         bit [63:0] acc;
         bit [63:0] rows;
         int cols;
         acc = 64'd1;
         rows = 64'(clamp_dim(rows_in));
         cols = clamp_dim(cols_in);
         for (int i = 1; i < cols; i++) begin
            acc = acc * (rows - 64'd1 + 64'(i)) / 64'(i);
         end
         return acc;
      endfunction

      function void note_request(bit [DIM_W-1:0] rows, bit [DIM_W-1:0] cols);
         path_expect_type item;
         bit [63:0] full;
         full = lattice_paths(rows, cols);
         item.rows = rows;
         item.cols = cols;
         item.count = full[PATH_W-1:0];
         pending_paths.push_back(item);
      endfunction

      function void check_response(logic [63:0] data);
         path_expect_type item;
         if (pending_paths.size() == 0) begin
            if (failures < 10)
               $display("%0t: response %0d arrived with no request outstanding",
                        $time, data[PATH_W-1:0]);
            failures++;
            return;
         end
         item = pending_paths.pop_front();
         if (data[PATH_W-1:0] !== item.count) begin
            if (failures < 10)
               $display("%0t: rows %0d cols %0d: path_count expected %0d, got %0d",
                        $time, item.rows, item.cols, item.count, data[PATH_W-1:0]);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending_paths.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;   // [5:0] grid_rows, [11:6] grid_cols, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;              // [58:0] path_count, rest zero

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   path_count_board board;

   grid_lattice_path_count uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata);
   end

   // The valid stays high after a request is taken, so back-to-back requests never
   // drop and raise it within the same step.
   task automatic send_request(input bit [DIM_W-1:0] rows, input bit [DIM_W-1:0] cols);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, cols, rows};
      do @(posedge clock); while (!req_tready);
      board.note_request(rows, cols);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      bit [DIM_W-1:0] directed_rows [20] = '{1, 0, 0, 5, 1, 32, 2, 3, 32, 63,
                                             33, 32, 63, 1, 31, 32, 16, 42, 10, 0};
      bit [DIM_W-1:0] directed_cols [20] = '{1, 0, 5, 0, 32, 1, 2, 3, 32, 63,
                                             32, 33, 1, 63, 32, 31, 17, 21, 10, 63};
      bit [DIM_W-1:0] rows;
      bit [DIM_W-1:0] cols;
      int sel;

      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) send_request(directed_rows[k], directed_cols[k]);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         for (int n = 0; n < 64; n++) begin
            if (n == 32) wait_for_drain();
            // Wide grids take more multiply-and-divide steps, so most requests stay narrow.
            sel = $urandom_range(99);
            if (sel < 70) cols = DIM_W'($urandom_range(12, 1));
            else if (sel < 85) cols = DIM_W'($urandom_range(63, 0));
            else cols = DIM_W'($urandom_range(32, 25));
            rows = ($urandom_range(99) < 60) ? DIM_W'($urandom_range(32, 1))
                                             : DIM_W'($urandom_range(63, 0));
            send_request(rows, cols);
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (board.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: grid_lattice_path_count.f
rtl/core/glpc_pkg.sv
rtl/core/glpc_mul.sv
rtl/core/glpc_div.sv
rtl/core/grid_lattice_path_count.sv
bench/tb_grid_lattice_path_count.sv
